/* design/ilst_pkg.sv */
// Shared types, field widths and codes of the interval latency statistics table.
package ilst_pkg;

    localparam int SLOTS      = 16;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int SLOT_IN_W  = 4;
    localparam int ACTION_W   = 2;
    localparam int STATUS_W   = 2;
    localparam int TIME_BITS  = 48;
    localparam int TOTAL_W    = 64;
    localparam int COUNT_W    = 32;

    localparam logic [ACTION_W-1:0] ACT_START = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_END   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NOP   = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_OVERLAP = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd2;

    typedef struct packed {
        logic [TIME_BITS-1:0] start_time;
        logic [TIME_BITS-1:0] min0;
        logic [TIME_BITS-1:0] min1;
        logic [TIME_BITS-1:0] max0;
        logic [TIME_BITS-1:0] max1;
        logic [TOTAL_W-1:0]   sum;
        logic [COUNT_W-1:0]   count;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [SLOT_IN_W-1:0] slot_out;
        logic [STATUS_W-1:0]  status;
        logic [TIME_BITS-1:0] duration;
        logic [TIME_BITS-1:0] smallest;
        logic [TIME_BITS-1:0] second_smallest;
        logic [TIME_BITS-1:0] largest;
        logic [TIME_BITS-1:0] second_largest;
        logic [TOTAL_W-1:0]   total;
        logic [COUNT_W-1:0]   completed;
    } result_t;

endpackage

/* design/ilst_event_if.sv */
// Input channel carrying one timing event per transaction.
interface ilst_event_if;
    logic                              valid;
    logic                              ready;
    logic [ilst_pkg::ACTION_W-1:0]     action;
    logic [ilst_pkg::SLOT_IN_W-1:0]    slot;
    logic [ilst_pkg::TIME_BITS-1:0]    timestamp;

    modport source (output valid, output action, output slot, output timestamp, input ready);
    modport sink   (input valid, input action, input slot, input timestamp, output ready);
endinterface

/* design/ilst_result_if.sv */
// Output channel carrying one slot report per transaction.
interface ilst_result_if;
    logic                              valid;
    logic                              ready;
    logic [ilst_pkg::SLOT_IN_W-1:0]    slot_out;
    logic [ilst_pkg::STATUS_W-1:0]     status;
    logic [ilst_pkg::TIME_BITS-1:0]    duration;
    logic [ilst_pkg::TIME_BITS-1:0]    smallest;
    logic [ilst_pkg::TIME_BITS-1:0]    second_smallest;
    logic [ilst_pkg::TIME_BITS-1:0]    largest;
    logic [ilst_pkg::TIME_BITS-1:0]    second_largest;
    logic [ilst_pkg::TOTAL_W-1:0]      total;
    logic [ilst_pkg::COUNT_W-1:0]      completed;

    modport source (output valid, output slot_out, output status, output duration,
                    output smallest, output second_smallest, output largest,
                    output second_largest, output total, output completed, input ready);
    modport sink   (input valid, input slot_out, input status, input duration,
                    input smallest, input second_smallest, input largest,
                    input second_largest, input total, input completed, output ready);
endinterface

/* design/ilst_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module ilst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/interval_latency_stats_table.sv */
// An accepted event goes through these steps: the transaction is taken, the slot's statistics
// are read from the single statistics memory, and then they are updated, written back and
// placed in the result register. The block takes no new event until the previous one has
// been written back, a limit set by this read-modify-write of the memory. The result
// register lets the next event be accepted while a report still waits; the update step waits
// only when the previous report has not yet been taken. Running and valid flags sit in
// flip-flops, so a clear takes effect at once and no clearing pass follows reset.
module interval_latency_stats_table (
    input  logic               clk,
    input  logic               rst_n,
    ilst_event_if.sink         events,
    ilst_result_if.source      results
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0]                       state_reg, state_next;
    logic [ilst_pkg::SLOTS-1:0]       valid_reg, valid_next;
    logic [ilst_pkg::SLOTS-1:0]       running_reg, running_next;
    logic                             out_valid_reg, out_valid_next;

    logic [ilst_pkg::ACTION_W-1:0]    action_reg;
    logic [ilst_pkg::SLOT_IN_W-1:0]   slot_reg;
    logic [ilst_pkg::TIME_BITS-1:0]   ts_reg;
    logic [ilst_pkg::TIME_BITS-1:0]   dur_reg;
    ilst_pkg::entry_t                 entry_reg;
    ilst_pkg::result_t                result_reg, result_next;

    logic                             in_fire;
    logic                             upd_fire;
    logic [ilst_pkg::SLOT_W-1:0]      idx;
    logic [ilst_pkg::ENTRY_W-1:0]     rd_data;
    ilst_pkg::entry_t                 rd_entry;
    ilst_pkg::entry_t                 new_entry;
    ilst_pkg::entry_t                 shown;
    logic                             wr_en;
    logic                             show;
    logic                             slot_v;
    logic                             slot_r;

    assign in_fire  = events.valid && events.ready;
    assign upd_fire = (state_reg == ST_UPD) && (!out_valid_reg || results.ready);
    assign idx      = slot_reg[ilst_pkg::SLOT_W-1:0];
    assign slot_v   = valid_reg[idx];
    assign slot_r   = running_reg[idx];
    assign rd_entry = ilst_pkg::entry_t'(rd_data);

    assign events.ready = (state_reg == ST_IDLE);

    ilst_ram #(
        .WIDTH (ilst_pkg::ENTRY_W),
        .DEPTH (ilst_pkg::SLOTS)
    ) u_stats_ram (
        .clk   (clk),
        .we    (wr_en && upd_fire),
        .waddr (idx),
        .wdata (new_entry),
        .raddr (events.slot[ilst_pkg::SLOT_W-1:0]),
        .rdata (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (upd_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Slot update and report for the event held in the update cycle.
    always_comb
    begin
        new_entry    = entry_reg;
        wr_en        = 1'b0;
        show         = slot_v;
        valid_next   = valid_reg;
        running_next = running_reg;
        result_next  = '0;
        result_next.slot_out = slot_reg;
        result_next.status   = ilst_pkg::STAT_OK;

        unique case (action_reg)
            ilst_pkg::ACT_START:
            begin
                show = 1'b1;
                if (slot_v && slot_r)
                begin
                    result_next.status = ilst_pkg::STAT_OVERLAP;
                end
                else
                begin
                    if (!slot_v)
                    begin
                        new_entry.min0  = '1;
                        new_entry.min1  = '1;
                        new_entry.max0  = '0;
                        new_entry.max1  = '0;
                        new_entry.sum   = '0;
                        new_entry.count = '0;
                    end
                    new_entry.start_time = ts_reg;
                    wr_en             = 1'b1;
                    valid_next[idx]   = 1'b1;
                    running_next[idx] = 1'b1;
                end
            end
            ilst_pkg::ACT_END:
            begin
                if (!(slot_v && slot_r))
                begin
                    result_next.status = ilst_pkg::STAT_IGNORED;
                end
                else
                begin
                    // A duration equal to a stored extreme leaves it in place.
                    if (entry_reg.min1 > dur_reg)
                    begin
                        if (entry_reg.min0 > dur_reg)
                        begin
                            new_entry.min1 = entry_reg.min0;
                            new_entry.min0 = dur_reg;
                        end
                        else
                        begin
                            new_entry.min1 = dur_reg;
                        end
                    end
                    if (entry_reg.max1 < dur_reg)
                    begin
                        if (entry_reg.max0 < dur_reg)
                        begin
                            new_entry.max1 = entry_reg.max0;
                            new_entry.max0 = dur_reg;
                        end
                        else
                        begin
                            new_entry.max1 = dur_reg;
                        end
                    end
                    new_entry.sum = entry_reg.sum
                        + {{(ilst_pkg::TOTAL_W - ilst_pkg::TIME_BITS){1'b0}}, dur_reg};
                    new_entry.count = entry_reg.count + {{(ilst_pkg::COUNT_W - 1){1'b0}}, 1'b1};
                    wr_en                = 1'b1;
                    running_next[idx]    = 1'b0;
                    result_next.duration = dur_reg;
                end
            end
            ilst_pkg::ACT_CLEAR:
            begin
                show         = 1'b0;
                valid_next   = '0;
                running_next = '0;
            end
            ilst_pkg::ACT_NOP:
            begin
                show = slot_v;
            end
        endcase

        shown = new_entry;
        if (show)
        begin
            result_next.smallest        = shown.min0;
            result_next.second_smallest = shown.min1;
            result_next.largest         = shown.max0;
            result_next.second_largest  = shown.max1;
            result_next.total           = shown.sum;
            result_next.completed       = shown.count;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (upd_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            running_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (upd_fire)
            begin
                valid_reg   <= valid_next;
                running_reg <= running_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            action_reg <= events.action;
            slot_reg   <= events.slot;
            ts_reg     <= events.timestamp;
        end
        if (state_reg == ST_READ)
        begin
            entry_reg <= rd_entry;
            dur_reg   <= ts_reg - rd_entry.start_time;
        end
        if (upd_fire)
        begin
            result_reg <= result_next;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.slot_out        = result_reg.slot_out;
    assign results.status          = result_reg.status;
    assign results.duration        = result_reg.duration;
    assign results.smallest        = result_reg.smallest;
    assign results.second_smallest = result_reg.second_smallest;
    assign results.largest         = result_reg.largest;
    assign results.second_largest  = result_reg.second_largest;
    assign results.total           = result_reg.total;
    assign results.completed       = result_reg.completed;

endmodule

/* tb/tb.sv */
// Self-checking testbench for the interval latency statistics table.
module tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1700;
    localparam int MAX_REPORTS  = 10;

    logic clk;
    logic rst_n;

    ilst_event_if  ev_if ();
    ilst_result_if res_if ();

    interval_latency_stats_table uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .events  (ev_if),
        .results (res_if)
    );

    // Shadow copy of the slot table.
    logic                          slot_live    [ilst_pkg::SLOTS];
    logic                          slot_run     [ilst_pkg::SLOTS];
    logic [ilst_pkg::TIME_BITS-1:0] open_stamp  [ilst_pkg::SLOTS];
    logic [ilst_pkg::TIME_BITS-1:0] low0        [ilst_pkg::SLOTS];
    logic [ilst_pkg::TIME_BITS-1:0] low1        [ilst_pkg::SLOTS];
    logic [ilst_pkg::TIME_BITS-1:0] high0       [ilst_pkg::SLOTS];
    logic [ilst_pkg::TIME_BITS-1:0] high1       [ilst_pkg::SLOTS];
    logic [ilst_pkg::TOTAL_W-1:0]   dur_total   [ilst_pkg::SLOTS];
    logic [ilst_pkg::COUNT_W-1:0]   done_count  [ilst_pkg::SLOTS];

    ilst_pkg::result_t report_q [$];

    int  mismatches;
    int  cycles;
    int  sink_stall;
    bit  source_gaps;
    bit  sink_gaps;
    int  n_opened, n_closed, n_overlap, n_ignored, n_cleared, n_nop, n_reports;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [ilst_pkg::TIME_BITS-1:0] rand_stamp();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[ilst_pkg::TIME_BITS-1:0];
    endfunction

    // Applies one event to the shadow table and returns the report it should produce.
    function automatic ilst_pkg::result_t predict_report(
        logic [ilst_pkg::ACTION_W-1:0] act,
        logic [ilst_pkg::SLOT_IN_W-1:0] slot,
        logic [ilst_pkg::TIME_BITS-1:0] stamp);
        ilst_pkg::result_t r;
        int s;
        logic [ilst_pkg::TIME_BITS-1:0] d;
        logic show;
        s = slot % ilst_pkg::SLOTS;
        r = '0;
        r.slot_out = slot;
        r.status = ilst_pkg::STAT_OK;
        show = 1'b0;
        case (act)
            ilst_pkg::ACT_START:
            begin
                if (slot_live[s] && slot_run[s])
                begin
                    r.status = ilst_pkg::STAT_OVERLAP;
                    n_overlap++;
                end
                else
                begin
                    if (!slot_live[s])
                    begin
                        low0[s] = '1;
                        low1[s] = '1;
                        high0[s] = '0;
                        high1[s] = '0;
                        dur_total[s] = '0;
                        done_count[s] = '0;
                        slot_live[s] = 1'b1;
                    end
                    open_stamp[s] = stamp;
                    slot_run[s] = 1'b1;
                    n_opened++;
                end
                show = 1'b1;
            end
            ilst_pkg::ACT_END:
            begin
                if (!slot_live[s] || !slot_run[s])
                begin
                    r.status = ilst_pkg::STAT_IGNORED;
                    show = slot_live[s];
                    n_ignored++;
                end
                else
                begin
                    d = stamp - open_stamp[s];
                    // Equal durations never displace a stored extreme.
                    if (low1[s] > d)
                    begin
                        if (low0[s] > d)
                        begin
                            low1[s] = low0[s];
                            low0[s] = d;
                        end
                        else
                            low1[s] = d;
                    end
                    if (high1[s] < d)
                    begin
                        if (high0[s] < d)
                        begin
                            high1[s] = high0[s];
                            high0[s] = d;
                        end
                        else
                            high1[s] = d;
                    end
                    dur_total[s] = dur_total[s] + ilst_pkg::TOTAL_W'(d);
                    done_count[s] = done_count[s] + ilst_pkg::COUNT_W'(1);
                    slot_run[s] = 1'b0;
                    r.duration = d;
                    show = 1'b1;
                    n_closed++;
                end
            end
            ilst_pkg::ACT_CLEAR:
            begin
                for (int i = 0; i < ilst_pkg::SLOTS; i++)
                begin
                    slot_live[i] = 1'b0;
                    slot_run[i] = 1'b0;
                end
                n_cleared++;
            end
            default:
            begin
                show = slot_live[s];
                n_nop++;
            end
        endcase
        if (show)
        begin
            r.smallest = low0[s];
            r.second_smallest = low1[s];
            r.largest = high0[s];
            r.second_largest = high1[s];
            r.total = dur_total[s];
            r.completed = done_count[s];
        end
        return r;
    endfunction

    // Sends one event and records its expected report once the transaction is taken.
    task automatic send_event(logic [ilst_pkg::ACTION_W-1:0] act,
                              logic [ilst_pkg::SLOT_IN_W-1:0] slot,
                              logic [ilst_pkg::TIME_BITS-1:0] stamp);
        if (source_gaps && $urandom_range(0, 4) == 0)
        begin
            ev_if.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        ev_if.valid     <= 1'b1;
        ev_if.action    <= act;
        ev_if.slot      <= slot;
        ev_if.timestamp <= stamp;
        do
            @(posedge clk);
        while (!ev_if.ready);
        report_q.push_back(predict_report(act, slot, stamp));
    endtask

    task automatic wait_all_reported();
        ev_if.valid <= 1'b0;
        while (report_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_report();
        ilst_pkg::result_t got;
        ilst_pkg::result_t want;
        string bad;
        got = '{res_if.slot_out, res_if.status, res_if.duration, res_if.smallest,
                res_if.second_smallest, res_if.largest, res_if.second_largest,
                res_if.total, res_if.completed};
        n_reports++;
        if (report_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("unexpected result transaction: %p", got);
            return;
        end
        want = report_q.pop_front();
        bad = "";
        if (got.slot_out !== want.slot_out)               bad = {bad, " slot_out"};
        if (got.status !== want.status)                   bad = {bad, " status"};
        if (got.duration !== want.duration)               bad = {bad, " duration"};
        if (got.smallest !== want.smallest)               bad = {bad, " smallest"};
        if (got.second_smallest !== want.second_smallest) bad = {bad, " second_smallest"};
        if (got.largest !== want.largest)                 bad = {bad, " largest"};
        if (got.second_largest !== want.second_largest)   bad = {bad, " second_largest"};
        if (got.total !== want.total)                     bad = {bad, " total"};
        if (got.completed !== want.completed)             bad = {bad, " completed"};
        if (bad != "")
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
            begin
                $display("result error at report %0d, fields:%s", n_reports, bad);
                $display("  expected %p", want);
                $display("  actual   %p", got);
            end
        end
    endtask

    // Result side: check every accepted transaction, then decide on back-pressure.
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            check_report();
        if (sink_gaps && sink_stall == 0 && $urandom_range(0, 5) == 0)
            sink_stall = $urandom_range(1, 17);
        if (sink_stall > 0)
        begin
            sink_stall--;
            res_if.ready <= 1'b0;
        end
        else
            res_if.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("run stopped after %0d cycles without completing", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic test_open_close_extremes();
        send_event(ilst_pkg::ACT_END, 4'd0, '0);
        send_event(ilst_pkg::ACT_START, 4'd0, '0);
        send_event(ilst_pkg::ACT_END, 4'd0, '1);
        send_event(ilst_pkg::ACT_START, 4'd15, '1);
        send_event(ilst_pkg::ACT_END, 4'd15, '0);
        send_event(ilst_pkg::ACT_START, 4'd15, 48'd100);
        send_event(ilst_pkg::ACT_END, 4'd15, 48'd100);
        send_event(ilst_pkg::ACT_START, 4'd15, 48'haaaa_aaaa_aaaa);
        send_event(ilst_pkg::ACT_END, 4'd15, 48'hffff_ffff_ffff);
    endtask

    task automatic test_overlap_and_stray_end();
        send_event(ilst_pkg::ACT_START, 4'd5, 48'h5555_5555_5555);
        send_event(ilst_pkg::ACT_START, 4'd5, 48'h0000_0000_0007);
        send_event(ilst_pkg::ACT_END, 4'd5, 48'h5555_5555_5556);
        send_event(ilst_pkg::ACT_END, 4'd5, 48'h5555_5555_5557);
        send_event(ilst_pkg::ACT_END, 4'd9, 48'd3);
    endtask

    task automatic test_ties();
        // Durations of one tie with the stored second smallest and second largest.
        send_event(ilst_pkg::ACT_START, 4'd15, 48'd10);
        send_event(ilst_pkg::ACT_END, 4'd15, 48'd11);
        send_event(ilst_pkg::ACT_START, 4'd15, 48'd20);
        send_event(ilst_pkg::ACT_END, 4'd15, 48'd21);
    endtask

    task automatic test_clear_and_nop();
        send_event(ilst_pkg::ACT_NOP, 4'd15, '1);
        send_event(ilst_pkg::ACT_NOP, 4'd3, '0);
        send_event(ilst_pkg::ACT_START, 4'd7, 48'd50);
        send_event(ilst_pkg::ACT_CLEAR, 4'd9, '1);
        send_event(ilst_pkg::ACT_END, 4'd7, 48'd60);
        send_event(ilst_pkg::ACT_START, 4'd15, 48'd1);
        send_event(ilst_pkg::ACT_END, 4'd15, 48'd2);
        send_event(ilst_pkg::ACT_CLEAR, 4'd0, '0);
    endtask

    task automatic test_random_sequences();
        int r;
        logic [ilst_pkg::SLOT_IN_W-1:0] s;
        logic [ilst_pkg::TIME_BITS-1:0] d;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Gaps on both sides, then a quiet stretch, gaps again, and none at the end.
            source_gaps = (n < 600) || (n >= 900 && n < 1400);
            sink_gaps = source_gaps;
            if (n == 900)
                wait_all_reported();
            r = $urandom_range(0, 99);
            s = ilst_pkg::SLOT_IN_W'($urandom_range(0, ilst_pkg::SLOTS - 1));
            if (r < 1)
                send_event(ilst_pkg::ACT_CLEAR, s, rand_stamp());
            else if (r < 10)
                send_event(ilst_pkg::ACTION_W'($urandom_range(0, 3)), s, rand_stamp());
            else if (slot_run[s])
            begin
                case ($urandom_range(0, 5))
                    0, 1:    d = ilst_pkg::TIME_BITS'($urandom_range(0, 7));
                    2:       d = rand_stamp();
                    3:       d = '1 - ilst_pkg::TIME_BITS'($urandom_range(0, 7));
                    4:       d = ilst_pkg::TIME_BITS'($urandom_range(0, 1000));
                    default: d = ilst_pkg::TIME_BITS'($urandom_range(0, 65535));
                endcase
                send_event(ilst_pkg::ACT_END, s, open_stamp[s] + d);
            end
            else
                send_event(ilst_pkg::ACT_START, s, rand_stamp());
        end
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        ev_if.valid     <= 1'b0;
        ev_if.action    <= ilst_pkg::ACT_NOP;
        ev_if.slot      <= '0;
        ev_if.timestamp <= '0;
        for (int i = 0; i < ilst_pkg::SLOTS; i++)
        begin
            slot_live[i] = 1'b0;
            slot_run[i] = 1'b0;
            open_stamp[i] = '0;
            low0[i] = '0;
            low1[i] = '0;
            high0[i] = '0;
            high1[i] = '0;
            dur_total[i] = '0;
            done_count[i] = '0;
        end
        source_gaps = 1'b1;
        sink_gaps = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_open_close_extremes();
        test_overlap_and_stray_end();
        test_ties();
        test_clear_and_nop();
        wait_all_reported();
        test_random_sequences();

        wait_all_reported();
        repeat (20) @(posedge clk);
        $display("covered %0d opened, %0d closed, %0d overlapping starts, %0d stray ends",
                 n_opened, n_closed, n_overlap, n_ignored);
        $display("plus %0d table clears and %0d unused-code events; %0d reports checked",
                 n_cleared, n_nop, n_reports);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
